FILE: sv/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

  localparam int WINDOW_MAX_DEF = 64;  // deque depth, largest usable window
  localparam int SAMPLE_W       = 32;
  localparam int WIN_CFG_W      = 7;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // take the input transaction
    logic drop_back;   // drop the newest candidate
    logic drop_front;  // drop the oldest candidate
    logic append;      // push the held sample, advance counters
    logic load_out;    // load the result register
  } swm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic back_lt;    // newest candidate is below the sample
    logic front_exp;  // oldest candidate has left the window
    logic emit;       // this sample produces a result
    logic out_free;   // result register can take a value this cycle
  } swm_sts_t;

endpackage

FILE: sv/sliding_window_maximum.sv
`timescale 1ns / 1ps

// Sliding window maximum over a stream of signed 32-bit samples.
// Input channel (in_*): one sample per transaction, in_tuser = 1 starts a new
// sequence (candidates, sample count and positions cleared first).
// Output channel (out_*): the maximum of the last window_size samples, one
// result per sample once window_size samples of the sequence have arrived;
// window_size = 0 gives no results, values above WINDOW_MAX act as WINDOW_MAX.
// Configuration: cfg_we writes cfg_wdata to window_size (reset value 1);
// write only while no sample is in flight.
// Steps: accept, drop candidates from the back, drop expired ones from the
// front (one removal per step at each end), then push; in_tready is high only
// between samples. Every sample is removed at most once. The candidate memory
// is read with registered data, one candidate compared per cycle at each end.
// The result is registered at the push step, after all removals.
// Reset (rst_n low, synchronous) empties the deque and the result register.
// A stalled receiver holds the result in its register; the next sample is
// still accepted and processed, and waits at its push step only if it has
// its own result to deliver.
module sliding_window_maximum #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  in_tdata,   // [31:0] sample
  input  logic                                 in_tuser,   // [0] first
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic signed [swm_pkg::SAMPLE_W-1:0]  out_tdata,  // [31:0] window_max
  input  logic                                 cfg_we,
  input  logic        [swm_pkg::WIN_CFG_W-1:0] cfg_wdata   // window_size
);
  import swm_pkg::*;

  swm_cmd_t cmd;
  swm_sts_t sts;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swm_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_sample (in_tdata),
    .in_first  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_max   (out_tdata)
  );

endmodule

FILE: sv/swm_ctrl.sv
`timescale 1ns / 1ps

module swm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swm_pkg::swm_sts_t sts,
  output swm_pkg::swm_cmd_t cmd
);
  import swm_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_BACK   = 2'd1;
  localparam logic [1:0] S_FRONT  = 2'd2;
  localparam logic [1:0] S_APPEND = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_BACK;
        end
      end
      S_BACK: begin
        if (sts.back_lt) begin
          cmd.drop_back = 1'b1;
        end else begin
          state_nxt = S_FRONT;
        end
      end
      S_FRONT: begin
        if (sts.front_exp) begin
          cmd.drop_front = 1'b1;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        // hold until the result register can take the value
        if (!sts.emit || sts.out_free) begin
          cmd.append   = 1'b1;
          cmd.load_out = sts.emit;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/swm_dp.sv
`timescale 1ns / 1ps

module swm_dp #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  swm_pkg::swm_cmd_t                    cmd,
  output swm_pkg::swm_sts_t                    sts,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_first,
  input  logic                                 cfg_we,
  input  logic        [swm_pkg::WIN_CFG_W-1:0] cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [swm_pkg::SAMPLE_W-1:0]  out_max
);
  import swm_pkg::*;

  localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int POS_W = $clog2(WINDOW_MAX) + 2;  // ages stay below 4x depth
  localparam int CMP_W = (POS_W > WIN_CFG_W) ? POS_W : WIN_CFG_W;
  localparam int ENT_W = SAMPLE_W + POS_W;

  localparam logic [AW-1:0]    LAST_SLOT = AW'(WINDOW_MAX - 1);
  localparam logic [AW:0]      MAX_SUM   = (AW + 1)'(WINDOW_MAX);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(WINDOW_MAX);
  localparam logic [CMP_W-1:0] MAX_CMP   = CMP_W'(WINDOW_MAX);

  logic [WIN_CFG_W-1:0]       win_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [AW-1:0]              head_r, head_nxt;
  logic [CNT_W-1:0]           occ_r, occ_nxt;
  logic [CNT_W-1:0]           seen_r, seen_nxt, seen_inc;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_max_r;

  logic [ENT_W-1:0] mem [WINDOW_MAX];
  logic [ENT_W-1:0] back_q, front_q;

  logic [AW-1:0]              tail_cur, tail_nxt, back_addr;
  logic signed [SAMPLE_W-1:0] back_val, front_val, emit_val;
  logic [POS_W-1:0]           age;
  logic [CMP_W-1:0]           win_ext, win_eff;

  // (h + o) mod WINDOW_MAX, o <= WINDOW_MAX
  function automatic logic [AW-1:0] slot_add(logic [AW-1:0] h, logic [CNT_W-1:0] o);
    logic [AW:0] s;
    s = (AW + 1)'(h) + (AW + 1)'(o);
    if (s >= MAX_SUM) begin
      s = s - MAX_SUM;
    end
    return s[AW-1:0];
  endfunction

  assign seen_inc = (seen_r == MAX_CNT) ? seen_r : seen_r + CNT_W'(1);

  always_comb begin
    head_nxt = head_r;
    occ_nxt  = occ_r;
    seen_nxt = seen_r;
    pos_nxt  = pos_r;
    if (cmd.accept && in_first) begin
      head_nxt = '0;
      occ_nxt  = '0;
      seen_nxt = '0;
      pos_nxt  = '0;
    end
    if (cmd.drop_back) begin
      occ_nxt = occ_r - CNT_W'(1);
    end
    if (cmd.drop_front) begin
      head_nxt = (head_r == LAST_SLOT) ? '0 : head_r + AW'(1);
      occ_nxt  = occ_r - CNT_W'(1);
    end
    if (cmd.append) begin
      occ_nxt  = occ_r + CNT_W'(1);
      pos_nxt  = pos_r + POS_W'(1);
      seen_nxt = seen_inc;
    end
  end

  // read addresses follow the next-state pointers so data lines up with the regs
  assign tail_cur  = slot_add(head_r, occ_r);
  assign tail_nxt  = slot_add(head_nxt, occ_nxt);
  assign back_addr = (tail_nxt == '0) ? LAST_SLOT : tail_nxt - AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[tail_cur] <= {pos_r, sample_r};
    end
    back_q  <= mem[back_addr];
    front_q <= mem[head_nxt];
  end

  assign back_val  = signed'(back_q[SAMPLE_W-1:0]);
  assign front_val = signed'(front_q[SAMPLE_W-1:0]);
  assign age       = pos_r - front_q[ENT_W-1:SAMPLE_W];
  assign win_ext   = CMP_W'(win_r);
  assign win_eff   = (win_ext > MAX_CMP) ? MAX_CMP : win_ext;
  assign emit_val  = (occ_r == '0) ? sample_r : front_val;

  always_comb begin
    sts.back_lt   = (occ_r != '0) && (back_val < sample_r);
    sts.front_exp = (occ_r != '0) && (CMP_W'(age) >= win_eff);
    sts.emit      = (win_eff != '0) && (CMP_W'(seen_inc) >= win_eff);
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WIN_CFG_W'(1);
      head_r      <= '0;
      occ_r       <= '0;
      seen_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_r <= cfg_wdata;
      end
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
      seen_r <= seen_nxt;
      pos_r  <= pos_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
    end
    if (cmd.load_out) begin
      out_max_r <= emit_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_max   = out_max_r;

  // window expiry keeps the deque short of full before each push
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> (occ_r < MAX_CNT))
    else $error("deque full at append");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_drop_back: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop_back |=> (occ_r == $past(occ_r) - CNT_W'(1)))
    else $error("back drop did not shrink deque");

endmodule
